@@ rtl/csad_pkg.sv @@
package csad_pkg;

  localparam int ADDR_W  = 25;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 22;
  localparam int WORD_W  = 20;
  localparam int LANES   = 4;
  localparam int LANE_W  = 2;

  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic AREA_MAIN = 1'b0;
  localparam logic AREA_ID   = 1'b1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef enum logic [1:0] {
    CART_NONE  = 2'd0,
    CART_RAM1M = 2'd1,
    CART_RAM4M = 2'd2,
    CART_ROM2M = 2'd3
  } cart_type_t;

  localparam logic [31:0]       SEL_RAM1M  = 32'h0000_0050;
  localparam logic [31:0]       SEL_RAM4M  = 32'h0000_00F0;
  localparam logic [DATA_W-1:0] CODE_RAM1M = 32'hFF5A_FF5A;
  localparam logic [DATA_W-1:0] CODE_RAM4M = 32'hFF5C_FF5C;
  localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] ID_TOP_B   = 25'hFF_FFFF;
  localparam logic [ADDR_W-1:0] ID_TOP_H   = 25'hFF_FFFE;
  localparam logic [ADDR_W-1:0] ID_TOP_W   = 25'hFF_FFFC;

  // One decoded access as it waits between the front and the back.
  typedef struct packed {
    logic              is_write;
    logic              is_mem;
    logic [1:0]        sz;
    logic [LANE_W-1:0] lane;
    logic [LANES-1:0]  be;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] data;
  } csad_op_t;

  typedef struct packed {
    logic     valid;
    csad_op_t op;
  } csad_opq_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    unique case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_HALF: m = 32'h0000_FFFF;
      default: m = ALL_ONES;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/csad_front.sv @@
module csad_front #(
  parameter int unsigned STORE_BYTES = 4194304
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_cmd,
  input  logic                       in_area,
  input  logic [1:0]                 in_size,
  input  logic [csad_pkg::ADDR_W-1:0] in_addr,
  input  logic [csad_pkg::DATA_W-1:0] in_write_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_cart_type,
  output csad_pkg::csad_opq_t        opq,
  input  logic                       op_pop
);
  import csad_pkg::*;

  localparam int unsigned STORE_WORDS = STORE_BYTES / 4;
  localparam logic [IDX_W:0]  LP_BYTES = (IDX_W + 1)'(STORE_BYTES);
  localparam logic [WORD_W:0] LP_WORDS = (WORD_W + 1)'(STORE_WORDS);

  cart_type_t        type_r;
  csad_op_t          q_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OPQ_CW-1:0] cnt_r, cnt_nxt;

  logic [1:0]        sz;
  logic [ADDR_W-1:0] a;
  logic [DATA_W-1:0] m;
  logic [31:0]       sel;
  logic              hit;
  logic [IDX_W-1:0]  idx_raw, idx;
  logic [IDX_W:0]    idx_sub;
  logic [WORD_W:0]   word_ext, word_sub;
  logic [WORD_W-1:0] word;
  logic [LANE_W-1:0] lane;
  logic [LANES-1:0]  be_base;
  logic [ADDR_W-1:0] id_top;
  logic [DATA_W-1:0] id_val;
  logic              keep, acc, push;
  csad_op_t          op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= CART_NONE;
    end else if (cfg_valid && cfg_ready) begin
      type_r <= cart_type_t'(cfg_cart_type);
    end
  end

  always_comb begin
    sz = (in_size == SZ_BYTE) ? SZ_BYTE : (in_size == SZ_HALF) ? SZ_HALF : SZ_WORD;
    a  = in_addr;
    if (sz == SZ_HALF) a[0] = 1'b0;
    if (sz == SZ_WORD) a[1:0] = 2'b00;
    m   = size_mask(sz);
    sel = 32'd1 << a[ADDR_W-1:20];

    unique case (type_r)
      CART_RAM1M: begin
        hit     = (sel & SEL_RAM1M) != 32'd0;
        idx_raw = {2'b00, a[21], a[18:0]};
      end
      CART_RAM4M: begin
        hit     = (sel & SEL_RAM4M) != 32'd0;
        idx_raw = a[IDX_W-1:0];
      end
      CART_ROM2M: begin
        hit     = 1'b1;
        idx_raw = {1'b0, a[20:0]};
      end
      default: begin
        hit     = 1'b0;
        idx_raw = '0;
      end
    endcase

    // The byte index is below twice the store size, so one subtraction wraps it.
    idx_sub = {1'b0, idx_raw} - LP_BYTES;
    idx     = ({1'b0, idx_raw} >= LP_BYTES) ? idx_sub[IDX_W-1:0] : idx_raw;

    word_ext = {1'b0, idx[IDX_W-1:2]};
    word_sub = word_ext - LP_WORDS;
    word     = (word_ext >= LP_WORDS) ? word_sub[WORD_W-1:0] : idx[IDX_W-1:2];

    unique case (sz)
      SZ_BYTE: begin
        lane    = 2'd3 - idx[1:0];
        be_base = 4'b0001;
        id_top  = ID_TOP_B;
      end
      SZ_HALF: begin
        lane    = idx[1] ? 2'd0 : 2'd2;
        be_base = 4'b0011;
        id_top  = ID_TOP_H;
      end
      default: begin
        lane    = 2'd0;
        be_base = 4'b1111;
        id_top  = ID_TOP_W;
      end
    endcase

    if (a == id_top) begin
      id_val = (type_r == CART_RAM1M) ? CODE_RAM1M :
               (type_r == CART_RAM4M) ? CODE_RAM4M : ALL_ONES;
    end else begin
      id_val = ALL_ONES;
    end

    op.is_write = (in_cmd == CMD_WRITE);
    op.is_mem   = (in_area == AREA_MAIN) && hit;
    op.sz       = sz;
    op.lane     = lane;
    op.be       = be_base << lane;
    op.word     = word;
    if (in_cmd == CMD_WRITE) begin
      op.data = (in_write_data & m) << {lane, 3'b000};
    end else if (in_area == AREA_ID) begin
      op.data = id_val & m;
    end else begin
      op.data = m;
    end

    // Writes that hit nothing are dropped here and never reach the back.
    keep = (in_cmd == CMD_READ) || op.is_mem;
  end

  assign in_full = (cnt_r == OPQ_CW'(OPQ_DEPTH));
  assign acc     = in_push && !in_full;
  assign push    = acc && keep;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !op_pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && op_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (op_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= op;
  end

  assign opq.valid = (cnt_r != '0);
  assign opq.op    = q_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OPQ_CW'(OPQ_DEPTH))
    else $error("op queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> cnt_r != '0)
    else $error("op queue popped while empty");

  a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !keep && !op_pop) |=> $stable(cnt_r))
    else $error("dropped write changed op queue");

endmodule

@@ rtl/csad_back.sv @@
module csad_back #(
  parameter int unsigned STORE_WORDS = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csad_pkg::csad_opq_t         opq,
  output logic                        op_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [csad_pkg::DATA_W-1:0] out_read_data
);
  import csad_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic [LANES-1:0][7:0] mem [STORE_WORDS];
  logic [DATA_W-1:0]     rd_r;
  logic [AW-1:0]         mem_addr;

  logic                  b_valid_r;
  logic                  b_mem_r;
  logic [1:0]            b_sz_r;
  logic [LANE_W-1:0]     b_lane_r;
  logic [DATA_W-1:0]     b_const_r;
  logic [DATA_W-1:0]     result;

  logic [DATA_W-1:0]     oq_r [OUT_DEPTH];
  logic [OUT_AW-1:0]     oq_wr_r, oq_rd_r;
  logic [OUT_CW-1:0]     oq_cnt_r, oq_cnt_nxt;
  logic [OUT_CW:0]       credit;
  logic                  oq_pop;

  // A read is issued only when the result queue can take it after the data stage.
  assign credit   = {1'b0, oq_cnt_r} + (OUT_CW + 1)'(b_valid_r);
  assign op_pop   = opq.valid && (credit < (OUT_CW + 1)'(OUT_DEPTH));
  assign mem_addr = opq.op.word[AW-1:0];

  always_ff @(posedge clk) begin
    if (op_pop && opq.op.is_mem) begin
      if (opq.op.is_write) begin
        for (int b = 0; b < LANES; b++) begin
          if (opq.op.be[b]) mem[mem_addr][b] <= opq.op.data[b*8 +: 8];
        end
      end else begin
        rd_r <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= op_pop && !opq.op.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      b_mem_r   <= opq.op.is_mem;
      b_sz_r    <= opq.op.sz;
      b_lane_r  <= opq.op.lane;
      b_const_r <= opq.op.data;
    end
  end

  assign result = b_mem_r ? ((rd_r >> {b_lane_r, 3'b000}) & size_mask(b_sz_r)) : b_const_r;

  assign oq_pop = out_pop && !out_empty;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (b_valid_r && !oq_pop) oq_cnt_nxt = oq_cnt_r + 1'b1;
    if (!b_valid_r && oq_pop) oq_cnt_nxt = oq_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (b_valid_r) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)    oq_rd_r <= oq_rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) oq_r[oq_wr_r] <= result;
  end

  assign out_empty     = (oq_cnt_r == '0);
  assign out_read_data = oq_r[oq_rd_r];

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OUT_CW'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_space_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> oq_cnt_r < OUT_CW'(OUT_DEPTH) || oq_pop)
    else $error("result arrives with no room in the result queue");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && !opq.op.is_write) |=> b_valid_r)
    else $error("issued read produced no result");

endmodule

@@ rtl/cartridge_slot_address_decoder.sv @@
// A read accepted at in_push passes through the op queue, the data stage registers and the
// result queue before it shows on the out_ ports.
// Throughput: one access per cycle while the op queue is fed and the result queue has room,
// set by the single store access the back end makes each cycle. A write is held in the op queue
// until the back end takes it into the store, and is seen by every later read.
// Reset clears both queues and sets the cartridge type to none; the store is not cleared.
module cartridge_slot_address_decoder #(
  parameter int unsigned STORE_BYTES = 4194304
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic                        in_area,
  input  logic [1:0]                  in_size,
  input  logic [csad_pkg::ADDR_W-1:0] in_addr,
  input  logic [csad_pkg::DATA_W-1:0] in_write_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [csad_pkg::DATA_W-1:0] out_read_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_cart_type
);
  import csad_pkg::*;

  localparam int unsigned STORE_WORDS = STORE_BYTES / 4;

  csad_opq_t opq;
  logic      op_pop;

  csad_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_area      (in_area),
    .in_size      (in_size),
    .in_addr      (in_addr),
    .in_write_data(in_write_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_cart_type(cfg_cart_type),
    .opq          (opq),
    .op_pop       (op_pop)
  );

  csad_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .opq          (opq),
    .op_pop       (op_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_read_data(out_read_data)
  );

endmodule
